// ----- src/psc_pkg.sv -----
// Shared types and constants for the ping-pong sample capture block.
// No dependencies; used by psc_capture_ctrl and ping_pong_sample_capture.
`default_nettype none

package psc_pkg;

   localparam int BLOCK_DEPTH = 512;
   localparam int SAMPLE_BITS = 8;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_READ    = 2'd1,
      REQ_RELEASE = 2'd2
   } req_kind_type;

   // which side, if any, completed on a tick
   typedef enum logic [1:0] {
      FILL_NONE   = 2'd0,
      FILL_FIRST  = 2'd1,
      FILL_SECOND = 2'd2
   } fill_event_type;

   // per-transaction status from the controller to the output stage
   typedef struct packed {
      logic           read_hit;
      logic           first_full;
      logic           second_full;
      fill_event_type filled_now;
      logic           acquiring;
   } rsp_status_type;

endpackage

`default_nettype wire

// ----- src/ping_pong_sample_capture.sv -----
// Top level of the ping-pong sample capture block: stream ports and output stage.
// Depends on psc_pkg, psc_capture_ctrl and psc_buffer_mem.
`default_nettype none

// Captures converter samples into two alternating block stores of BLOCK_DEPTH
// entries. Every req transaction (tick, read or release) yields exactly one
// rsp transaction. The block takes one transaction per clock cycle while not
// stalled, and presents its response in the cycle after acceptance, from the
// memory's registered read port. The response register holds while
// rsp_tready is low, and a new request is taken whenever that register is empty
// or is being drained in the same cycle. Bytes never written read back as
// unspecified values; a read at or beyond BLOCK_DEPTH returns zero.
module ping_pong_sample_capture #(
   parameter int BLOCK_DEPTH = psc_pkg::BLOCK_DEPTH,
   parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] sample, [8] record_enable, [9] buf_select, [18:10] read_index, [23:19] zero
   input  wire logic [23:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] read_data, [8] first_full, [9] second_full, [11:10] filled_now,
   // [12] acquiring, [15:13] zero
   output logic      [15:0] rsp_tdata
);

   localparam int AddrBits = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

   logic                    req_fire;
   logic                    wr_en;
   logic                    wr_side;
   logic [AddrBits-1:0]     wr_addr;
   logic [SAMPLE_BITS-1:0]  wr_data;
   logic                    rd_en;
   logic                    rd_side;
   logic [AddrBits-1:0]     rd_addr;
   logic [SAMPLE_BITS-1:0]  rd_data;
   logic [15:0]             rd_wide;
   psc_pkg::rsp_status_type status;

   // response stage
   logic                    rsp_valid_ff, rsp_valid_in;
   psc_pkg::rsp_status_type rsp_status_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   psc_capture_ctrl #(
      .BLOCK_DEPTH (BLOCK_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ADDR_BITS   (AddrBits)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .item_fire     (req_fire),
      .req_kind      (req_tuser),
      .sample        (req_tdata[7:0]),
      .record_enable (req_tdata[8]),
      .buf_select    (req_tdata[9]),
      .read_index    (req_tdata[18:10]),
      .wr_en         (wr_en),
      .wr_side       (wr_side),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_side       (rd_side),
      .rd_addr       (rd_addr),
      .status        (status)
   );

   psc_buffer_mem #(
      .DEPTH     (BLOCK_DEPTH),
      .ADDR_BITS (AddrBits),
      .DATA_BITS (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_side (wr_side),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_side (rd_side),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // valid: set on accept, cleared when drained without a new accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status;
      end
   end

   // memory read data arrives alongside the registered status
   assign rd_wide = 16'(rd_data);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0,
                        rsp_status_ff.acquiring,
                        rsp_status_ff.filled_now,
                        rsp_status_ff.second_full,
                        rsp_status_ff.first_full,
                        (rsp_status_ff.read_hit ? rd_wide[7:0] : 8'd0)};

endmodule

`default_nettype wire

// ----- src/psc_buffer_mem.sv -----
// Two sample block stores (ping and pong) with one write and one registered read port.
// Standalone; driven by psc_capture_ctrl through the top level.
`default_nettype none

module psc_buffer_mem #(
   parameter int DEPTH     = 512,
   parameter int ADDR_BITS = 9,
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic                 wr_side,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic                 rd_side,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] first_mem  [DEPTH];
   logic [DATA_BITS-1:0] second_mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_side) begin
         first_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_side) begin
         second_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rd_side ? second_mem[rd_addr] : first_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/psc_capture_ctrl.sv -----
// Capture controller: acquire state, current side, fill index and full flags.
// Depends on psc_pkg; drives the ports of psc_buffer_mem.
`default_nettype none

module psc_capture_ctrl #(
   parameter int BLOCK_DEPTH = psc_pkg::BLOCK_DEPTH,
   parameter int SAMPLE_BITS = psc_pkg::SAMPLE_BITS,
   parameter int ADDR_BITS   = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_fire,
   input  wire logic [1:0]             req_kind,
   input  wire logic [7:0]             sample,
   input  wire logic                   record_enable,
   input  wire logic                   buf_select,
   input  wire logic [8:0]             read_index,
   output logic                        wr_en,
   output logic                        wr_side,
   output logic      [ADDR_BITS-1:0]   wr_addr,
   output logic      [SAMPLE_BITS-1:0] wr_data,
   output logic                        rd_en,
   output logic                        rd_side,
   output logic      [ADDR_BITS-1:0]   rd_addr,
   output psc_pkg::rsp_status_type     status
);

   typedef enum logic [1:0] {
      ST_IDLE    = 2'b01,
      ST_ACQUIRE = 2'b10
   } state_type;

   localparam logic [ADDR_BITS-1:0] LastIndex = ADDR_BITS'(BLOCK_DEPTH - 1);

   state_type              mode_ff, mode_in;
   logic                   side_ff, side_in;
   logic [ADDR_BITS-1:0]   fill_ff, fill_in;
   logic                   first_full_ff, first_full_in;
   logic                   second_full_ff, second_full_in;
   logic [31:0]            index_wide;
   logic [15:0]            sample_wide;
   logic                   read_in_range;
   logic                   read_hit;
   psc_pkg::fill_event_type filled;

   assign index_wide    = {23'd0, read_index};
   assign sample_wide   = {8'd0, sample};
   assign read_in_range = (index_wide < 32'(BLOCK_DEPTH));

   assign wr_side = side_ff;
   assign wr_addr = fill_ff;
   assign wr_data = sample_wide[SAMPLE_BITS-1:0];
   assign rd_side = buf_select;
   assign rd_addr = index_wide[ADDR_BITS-1:0];

   always_comb begin
      mode_in        = mode_ff;
      side_in        = side_ff;
      fill_in        = fill_ff;
      first_full_in  = first_full_ff;
      second_full_in = second_full_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      read_hit       = 1'b0;
      filled         = psc_pkg::FILL_NONE;
      if (item_fire) begin
         case (psc_pkg::req_kind_type'(req_kind))
            psc_pkg::REQ_TICK: begin
               if (mode_ff == ST_IDLE) begin
                  fill_in = '0;
                  if (record_enable) begin
                     mode_in = ST_ACQUIRE;
                  end
               end else begin
                  if (!side_ff && !first_full_ff) begin
                     wr_en = 1'b1;
                     if (fill_ff == LastIndex) begin
                        first_full_in = 1'b1;
                        side_in       = 1'b1;
                        fill_in       = '0;
                        filled        = psc_pkg::FILL_FIRST;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end else if (side_ff && !second_full_ff) begin
                     wr_en = 1'b1;
                     if (fill_ff == LastIndex) begin
                        second_full_in = 1'b1;
                        side_in        = 1'b0;
                        fill_in        = '0;
                        filled         = psc_pkg::FILL_SECOND;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  if (!record_enable) begin
                     mode_in = ST_IDLE;
                  end
               end
            end
            psc_pkg::REQ_READ: begin
               rd_en    = read_in_range;
               read_hit = read_in_range;
            end
            psc_pkg::REQ_RELEASE: begin
               if (buf_select) begin
                  second_full_in = 1'b0;
               end else begin
                  first_full_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status.read_hit    = read_hit;
      status.first_full  = first_full_in;
      status.second_full = second_full_in;
      status.filled_now  = filled;
      status.acquiring   = (mode_in == ST_ACQUIRE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ST_IDLE;
         side_ff        <= 1'b0;
         fill_ff        <= '0;
         first_full_ff  <= 1'b0;
         second_full_ff <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         side_ff        <= side_in;
         fill_ff        <= fill_in;
         first_full_ff  <= first_full_in;
         second_full_ff <= second_full_in;
      end
   end

   // one memory access per transaction
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("write and read issued together");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      {{(32-ADDR_BITS){1'b0}}, fill_ff} < 32'(BLOCK_DEPTH))
      else $error("fill index past block end");

   a_write_needs_acquire: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (mode_ff == ST_ACQUIRE))
      else $error("sample written while idle");

   a_fill_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (filled == psc_pkg::FILL_FIRST) |=> (first_full_ff && side_ff && fill_ff == '0))
      else $error("first side completion not recorded");

endmodule

`default_nettype wire
